// File: rtl/qrpy_pkg.sv
// qrpy_pkg: shared types, constants and the microprogram of the relative attitude block.
// No dependencies; imported by every module in rtl/.
package qrpy_pkg;

    localparam int XY_W     = 56;
    localparam int ANG_W    = 38;
    localparam int MUL_W    = 32;
    localparam int ACC_W    = 64;
    localparam int ATAN_LEN = 24;
    localparam int STEP_W   = 5;
    localparam int PC_W     = 6;

    localparam logic [PC_W-1:0] UC_LAST = 6'd59;

    localparam logic signed [ACC_W-1:0] ONE_SQ    = 64'sd1073676289;
    localparam logic signed [ACC_W-1:0] ONE_SQ_SQ = ONE_SQ * ONE_SQ;
    localparam logic signed [ANG_W-1:0] PI_Q30     = 38'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 38'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_Q30   = 56'sd652032874;

    typedef enum logic [1:0] {MAC_NONE, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_t;

    typedef enum logic [4:0] {
        OP_CW, OP_CX, OP_CY, OP_CZ, OP_GW, OP_GX, OP_GY, OP_GZ,
        OP_AW, OP_AX, OP_AY, OP_AZ, OP_CO, OP_SI, OP_SP,
        OP_R20, OP_R21, OP_R22, OP_G00, OP_G10, OP_G20, OP_G02, OP_G12, OP_G22
    } opnd_t;

    typedef enum logic [4:0] {
        D_NONE, D_VY_DBL, D_VX_ONE, D_SP, D_VX_CP, D_CYAW, D_GYAW, D_PITCH, D_ERR,
        D_SINCOS, D_AW, D_AX, D_AY, D_AZ, D_G00, D_G10, D_G20, D_G02, D_G12, D_G22,
        D_R20, D_R21, D_R22, D_VY_NEG, D_VX_ACC
    } dst_t;

    typedef enum logic [2:0] {
        K_NONE, K_VEC, K_ROT, K_SQRT, K_WCOR, K_WSQRT, K_WWRAP, K_FINISH
    } kind_t;

    typedef struct packed {
        mac_op_t mac;
        opnd_t   opa;
        opnd_t   opb;
        dst_t    dst;
        kind_t   kind;
    } ucode_t;

    typedef struct packed {
        logic    in_load;
        mac_op_t mac;
        opnd_t   opa;
        opnd_t   opb;
        dst_t    dst;
        logic    cordic_start;
        logic    cordic_rot;
        logic    sqrt_start;
        logic    wrap_en;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_busy;
        logic sqrt_busy;
        logic err_ok;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic ucode_t uc(input mac_op_t m, input opnd_t a, input opnd_t b,
                                  input dst_t d, input kind_t k);
        ucode_t u;
        u.mac  = m;
        u.opa  = a;
        u.opb  = b;
        u.dst  = d;
        u.kind = k;
        return u;
    endfunction

    // destination writes use the accumulator as it stood before the same step
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t u;
        case (pc)
            6'd0:    u = uc(MAC_LOAD, OP_CW,  OP_CZ,  D_NONE,   K_NONE);
            6'd1:    u = uc(MAC_ADD,  OP_CX,  OP_CY,  D_NONE,   K_NONE);
            6'd2:    u = uc(MAC_LOAD, OP_CY,  OP_CY,  D_VY_DBL, K_NONE);
            6'd3:    u = uc(MAC_ADD,  OP_CZ,  OP_CZ,  D_NONE,   K_NONE);
            6'd4:    u = uc(MAC_LOAD, OP_CW,  OP_CY,  D_VX_ONE, K_NONE);
            6'd5:    u = uc(MAC_SUB,  OP_CX,  OP_CZ,  D_NONE,   K_VEC);
            6'd6:    u = uc(MAC_NONE, OP_CW,  OP_CW,  D_SP,     K_NONE);
            6'd7:    u = uc(MAC_LOAD, OP_SP,  OP_SP,  D_NONE,   K_NONE);
            6'd8:    u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_SQRT);
            6'd9:    u = uc(MAC_LOAD, OP_GW,  OP_GZ,  D_NONE,   K_NONE);
            6'd10:   u = uc(MAC_ADD,  OP_GX,  OP_GY,  D_NONE,   K_NONE);
            6'd11:   u = uc(MAC_LOAD, OP_GY,  OP_GY,  D_VY_DBL, K_NONE);
            6'd12:   u = uc(MAC_ADD,  OP_GZ,  OP_GZ,  D_NONE,   K_NONE);
            6'd13:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_VX_ONE, K_WCOR);
            6'd14:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_CYAW,   K_VEC);
            6'd15:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_WSQRT);
            6'd16:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_VX_CP,  K_WCOR);
            6'd17:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_GYAW,   K_VEC);
            6'd18:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_ERR,    K_NONE);
            6'd19:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_WWRAP);
            6'd20:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_WCOR);
            6'd21:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_PITCH,  K_ROT);
            6'd22:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_WCOR);
            6'd23:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_SINCOS, K_NONE);
            6'd24:   u = uc(MAC_LOAD, OP_CO,  OP_CW,  D_NONE,   K_NONE);
            6'd25:   u = uc(MAC_SUB,  OP_SI,  OP_CZ,  D_NONE,   K_NONE);
            6'd26:   u = uc(MAC_LOAD, OP_CO,  OP_CX,  D_AW,     K_NONE);
            6'd27:   u = uc(MAC_SUB,  OP_SI,  OP_CY,  D_NONE,   K_NONE);
            6'd28:   u = uc(MAC_LOAD, OP_CO,  OP_CY,  D_AX,     K_NONE);
            6'd29:   u = uc(MAC_ADD,  OP_SI,  OP_CX,  D_NONE,   K_NONE);
            6'd30:   u = uc(MAC_LOAD, OP_CO,  OP_CZ,  D_AY,     K_NONE);
            6'd31:   u = uc(MAC_ADD,  OP_SI,  OP_CW,  D_NONE,   K_NONE);
            6'd32:   u = uc(MAC_LOAD, OP_GY,  OP_GY,  D_AZ,     K_NONE);
            6'd33:   u = uc(MAC_ADD,  OP_GZ,  OP_GZ,  D_NONE,   K_NONE);
            6'd34:   u = uc(MAC_LOAD, OP_GX,  OP_GY,  D_G00,    K_NONE);
            6'd35:   u = uc(MAC_ADD,  OP_GW,  OP_GZ,  D_NONE,   K_NONE);
            6'd36:   u = uc(MAC_LOAD, OP_GX,  OP_GZ,  D_G10,    K_NONE);
            6'd37:   u = uc(MAC_SUB,  OP_GW,  OP_GY,  D_NONE,   K_NONE);
            6'd38:   u = uc(MAC_LOAD, OP_GX,  OP_GZ,  D_G20,    K_NONE);
            6'd39:   u = uc(MAC_ADD,  OP_GW,  OP_GY,  D_NONE,   K_NONE);
            6'd40:   u = uc(MAC_LOAD, OP_GY,  OP_GZ,  D_G02,    K_NONE);
            6'd41:   u = uc(MAC_SUB,  OP_GW,  OP_GX,  D_NONE,   K_NONE);
            6'd42:   u = uc(MAC_LOAD, OP_GX,  OP_GX,  D_G12,    K_NONE);
            6'd43:   u = uc(MAC_ADD,  OP_GY,  OP_GY,  D_NONE,   K_NONE);
            6'd44:   u = uc(MAC_LOAD, OP_AX,  OP_AZ,  D_G22,    K_NONE);
            6'd45:   u = uc(MAC_ADD,  OP_AW,  OP_AY,  D_NONE,   K_NONE);
            6'd46:   u = uc(MAC_LOAD, OP_AY,  OP_AZ,  D_R20,    K_NONE);
            6'd47:   u = uc(MAC_SUB,  OP_AW,  OP_AX,  D_NONE,   K_NONE);
            6'd48:   u = uc(MAC_LOAD, OP_AX,  OP_AX,  D_R21,    K_NONE);
            6'd49:   u = uc(MAC_ADD,  OP_AY,  OP_AY,  D_NONE,   K_NONE);
            6'd50:   u = uc(MAC_LOAD, OP_R20, OP_G00, D_R22,    K_NONE);
            6'd51:   u = uc(MAC_ADD,  OP_R21, OP_G10, D_NONE,   K_NONE);
            6'd52:   u = uc(MAC_ADD,  OP_R22, OP_G20, D_NONE,   K_NONE);
            6'd53:   u = uc(MAC_LOAD, OP_R20, OP_G02, D_VY_NEG, K_NONE);
            6'd54:   u = uc(MAC_ADD,  OP_R21, OP_G12, D_NONE,   K_NONE);
            6'd55:   u = uc(MAC_ADD,  OP_R22, OP_G22, D_NONE,   K_NONE);
            6'd56:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_VX_ACC, K_NONE);
            6'd57:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_VEC);
            6'd58:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_WCOR);
            6'd59:   u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_FINISH);
            default: u = uc(MAC_NONE, OP_CW,  OP_CW,  D_NONE,   K_FINISH);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/qrpy_cordic.sv
// qrpy_cordic: shared iterative CORDIC, vectoring (atan2) and rotation (sin/cos).
// Depends on qrpy_pkg.
module qrpy_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                rotate,
    input  logic signed [qrpy_pkg::XY_W-1:0]    x_in,
    input  logic signed [qrpy_pkg::XY_W-1:0]    y_in,
    input  logic signed [qrpy_pkg::ANG_W-1:0]   z_in,
    output logic                                busy,
    output logic signed [qrpy_pkg::XY_W-1:0]    x_out,
    output logic signed [qrpy_pkg::XY_W-1:0]    y_out,
    output logic signed [qrpy_pkg::ANG_W-1:0]   z_out
);
    import qrpy_pkg::*;

    localparam int N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N - 1);

    logic signed [XY_W-1:0]  x_reg, y_reg, dx, dy;
    logic signed [ANG_W-1:0] z_reg, tab;
    logic [STEP_W-1:0]       step_reg;
    logic                    busy_reg, rot_reg, pos;

    assign dx    = x_reg >>> step_reg;
    assign dy    = y_reg >>> step_reg;
    assign tab   = signed'(ANG_W'(atan_entry(step_reg)));
    assign pos   = rot_reg ? ~z_reg[ANG_W-1] : (y_reg <= 0);
    assign busy  = busy_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= rotate || (x_in != 0) || (y_in != 0);
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= (step_reg != LAST_STEP);
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rot_reg <= rotate;
            if (rotate)
            begin
                x_reg <= GAIN_Q30;
                y_reg <= '0;
                z_reg <= z_in;
            end
            else if (x_in < 0 && y_in >= 0)
            begin
                x_reg <= y_in;
                y_reg <= -x_in;
                z_reg <= HALF_PI_Q30;
            end
            else if (x_in < 0)
            begin
                x_reg <= -y_in;
                y_reg <= x_in;
                z_reg <= -HALF_PI_Q30;
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (pos)
            begin
                x_reg <= x_reg - dy;
                y_reg <= y_reg + dx;
                z_reg <= z_reg - tab;
            end
            else
            begin
                x_reg <= x_reg + dy;
                y_reg <= y_reg - dx;
                z_reg <= z_reg + tab;
            end
        end
    end

endmodule

// File: rtl/qrpy_isqrt.sv
// qrpy_isqrt: bit-pair integer square root of a 64-bit value, one bit pair per cycle.
// Depends on qrpy_pkg.
module qrpy_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        busy,
    output logic [31:0] root
);
    import qrpy_pkg::*;

    logic [63:0] v_reg, r_reg, bit_reg, trial;
    logic        busy_reg;

    assign trial = r_reg + bit_reg;
    assign busy  = busy_reg;
    assign root  = r_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (busy_reg)
            busy_reg <= ~bit_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= val;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// File: rtl/qrpy_dp.sv
// qrpy_dp: datapath - chassis store, operand registers, multiply-accumulate, result regs.
// Depends on qrpy_pkg, qrpy_cordic and qrpy_isqrt.
module qrpy_dp #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qrpy_pkg::dp_cmd_t   cmd,
    output qrpy_pkg::dp_stat_t  stat,
    input  logic                chassis_valid,
    input  logic signed [15:0]  chassis_w,
    input  logic signed [15:0]  chassis_x,
    input  logic signed [15:0]  chassis_y,
    input  logic signed [15:0]  chassis_z,
    input  logic signed [15:0]  gimbal_w,
    input  logic signed [15:0]  gimbal_x,
    input  logic signed [15:0]  gimbal_y,
    input  logic signed [15:0]  gimbal_z,
    input  logic signed [15:0]  relative_yaw,
    input  logic                out_stall,
    output logic                out_valid,
    output logic signed [15:0]  chassis_yaw,
    output logic signed [14:0]  chassis_pitch,
    output logic signed [15:0]  relative_pitch
);
    import qrpy_pkg::*;

    localparam int RY_SH = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] RND_HALF = ANG_W'(1 << (RY_SH - 1));
    localparam logic signed [ANG_W-1:0] MAX16 = ANG_W'(32767);
    localparam logic signed [ANG_W-1:0] MIN16 = ANG_W'(-32768);
    localparam logic signed [ANG_W-1:0] MAX15 = ANG_W'(16383);
    localparam logic signed [ANG_W-1:0] MIN15 = ANG_W'(-16384);

    logic signed [15:0]      cw_reg, cx_reg, cy_reg, cz_reg;
    logic signed [15:0]      gw_reg, gx_reg, gy_reg, gz_reg, ry_reg;
    logic signed [16:0]      aw_reg, ax_reg, ay_reg, az_reg;
    logic signed [31:0]      co_reg, si_reg, sp_reg;
    logic signed [26:0]      r20_reg, r21_reg, r22_reg;
    logic signed [25:0]      g00_reg, g10_reg, g20_reg, g02_reg, g12_reg, g22_reg;
    logic signed [XY_W-1:0]  vx_reg, vy_reg;
    logic signed [ANG_W-1:0] cyaw_reg, gyaw_reg, pitch_reg, err_reg, ry_ext;
    logic signed [ACC_W-1:0] acc_reg, prod, dbl, one_m, rnd30, rnd8_dbl, rnd8_one, sp_cl;
    logic signed [MUL_W-1:0] op_a, op_b;
    logic                    out_valid_reg;
    logic signed [15:0]      yaw_out_reg, rp_out_reg;
    logic signed [14:0]      pitch_out_reg;
    logic signed [ANG_W-1:0] yaw_sat, pitch_sat, rp_sat;

    logic signed [XY_W-1:0]  cx_out, cy_out;
    logic signed [ANG_W-1:0] cz_out;
    logic                    cordic_busy, sqrt_busy;
    logic [31:0]             sq_root;

    function automatic logic signed [ANG_W-1:0] ang_round(input logic signed [ANG_W-1:0] z);
        return (z + RND_HALF) >>> RY_SH;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat(input logic signed [ANG_W-1:0] v,
                                                    input logic signed [ANG_W-1:0] hi,
                                                    input logic signed [ANG_W-1:0] lo);
        logic signed [ANG_W-1:0] r;
        r = v;
        if (v > hi)
            r = hi;
        if (v < lo)
            r = lo;
        return r;
    endfunction

    function automatic logic signed [MUL_W-1:0] pick(
        input opnd_t sel,
        input logic signed [15:0] cw, cx, cy, cz, gw, gx, gy, gz,
        input logic signed [16:0] aw, ax, ay, az,
        input logic signed [31:0] co, si, sp,
        input logic signed [26:0] r20, r21, r22,
        input logic signed [25:0] g00, g10, g20, g02, g12, g22);
        logic signed [MUL_W-1:0] v;
        case (sel)
            OP_CW:   v = MUL_W'(cw);
            OP_CX:   v = MUL_W'(cx);
            OP_CY:   v = MUL_W'(cy);
            OP_CZ:   v = MUL_W'(cz);
            OP_GW:   v = MUL_W'(gw);
            OP_GX:   v = MUL_W'(gx);
            OP_GY:   v = MUL_W'(gy);
            OP_GZ:   v = MUL_W'(gz);
            OP_AW:   v = MUL_W'(aw);
            OP_AX:   v = MUL_W'(ax);
            OP_AY:   v = MUL_W'(ay);
            OP_AZ:   v = MUL_W'(az);
            OP_CO:   v = co;
            OP_SI:   v = si;
            OP_SP:   v = sp;
            OP_R20:  v = MUL_W'(r20);
            OP_R21:  v = MUL_W'(r21);
            OP_R22:  v = MUL_W'(r22);
            OP_G00:  v = MUL_W'(g00);
            OP_G10:  v = MUL_W'(g10);
            OP_G20:  v = MUL_W'(g20);
            OP_G02:  v = MUL_W'(g02);
            OP_G12:  v = MUL_W'(g12);
            OP_G22:  v = MUL_W'(g22);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign op_a = pick(cmd.opa, cw_reg, cx_reg, cy_reg, cz_reg, gw_reg, gx_reg, gy_reg,
                       gz_reg, aw_reg, ax_reg, ay_reg, az_reg, co_reg, si_reg, sp_reg,
                       r20_reg, r21_reg, r22_reg, g00_reg, g10_reg, g20_reg, g02_reg,
                       g12_reg, g22_reg);
    assign op_b = pick(cmd.opb, cw_reg, cx_reg, cy_reg, cz_reg, gw_reg, gx_reg, gy_reg,
                       gz_reg, aw_reg, ax_reg, ay_reg, az_reg, co_reg, si_reg, sp_reg,
                       r20_reg, r21_reg, r22_reg, g00_reg, g10_reg, g20_reg, g02_reg,
                       g12_reg, g22_reg);
    assign prod = op_a * op_b;

    assign dbl      = acc_reg <<< 1;
    assign one_m    = ONE_SQ - dbl;
    assign rnd30    = (acc_reg + 64'sd536870912) >>> 30;
    assign rnd8_dbl = (dbl + 64'sd128) >>> 8;
    assign rnd8_one = (one_m + 64'sd128) >>> 8;
    assign sp_cl    = (dbl > ONE_SQ) ? ONE_SQ : ((dbl < -ONE_SQ) ? -ONE_SQ : dbl);
    assign ry_ext   = ANG_W'(ry_reg) <<< RY_SH;

    assign yaw_sat   = sat(ang_round(cyaw_reg), MAX16, MIN16);
    assign pitch_sat = sat(ang_round(pitch_reg), MAX15, MIN15);
    assign rp_sat    = sat(ang_round(cz_out), MAX16, MIN16);

    qrpy_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.cordic_start),
        .rotate (cmd.cordic_rot),
        .x_in   (vx_reg),
        .y_in   (vy_reg),
        .z_in   (err_reg >>> 1),
        .busy   (cordic_busy),
        .x_out  (cx_out),
        .y_out  (cy_out),
        .z_out  (cz_out)
    );

    qrpy_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .val   (ONE_SQ_SQ - acc_reg),
        .busy  (sqrt_busy),
        .root  (sq_root)
    );

    assign stat.cordic_busy = cordic_busy;
    assign stat.sqrt_busy   = sqrt_busy;
    assign stat.err_ok      = (err_reg <= PI_Q30) && (err_reg >= -PI_Q30);
    assign stat.out_busy    = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
        end
        else if (cmd.in_load && chassis_valid)
        begin
            cw_reg <= chassis_w;
            cx_reg <= chassis_x;
            cy_reg <= chassis_y;
            cz_reg <= chassis_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            gw_reg <= gimbal_w;
            gx_reg <= gimbal_x;
            gy_reg <= gimbal_y;
            gz_reg <= gimbal_z;
            ry_reg <= relative_yaw;
        end

        case (cmd.mac)
            MAC_LOAD: acc_reg <= prod;
            MAC_ADD:  acc_reg <= acc_reg + prod;
            MAC_SUB:  acc_reg <= acc_reg - prod;
            default:  acc_reg <= acc_reg;
        endcase

        if (cmd.wrap_en)
        begin
            if (err_reg > PI_Q30)
                err_reg <= err_reg - TWO_PI_Q30;
            else if (err_reg < -PI_Q30)
                err_reg <= err_reg + TWO_PI_Q30;
        end

        case (cmd.dst)
            D_VY_DBL: vy_reg <= dbl[XY_W-1:0];
            D_VX_ONE: vx_reg <= one_m[XY_W-1:0];
            D_SP:     sp_reg <= sp_cl[31:0];
            D_VX_CP:
            begin
                vx_reg <= XY_W'(sq_root);
                vy_reg <= XY_W'(sp_reg);
            end
            D_CYAW:   cyaw_reg <= cz_out;
            D_GYAW:   gyaw_reg <= cz_out;
            D_PITCH:  pitch_reg <= cz_out;
            D_ERR:    err_reg <= gyaw_reg - cyaw_reg - ry_ext;
            D_SINCOS:
            begin
                co_reg <= cx_out[31:0];
                si_reg <= cy_out[31:0];
            end
            D_AW:     aw_reg <= rnd30[16:0];
            D_AX:     ax_reg <= rnd30[16:0];
            D_AY:     ay_reg <= rnd30[16:0];
            D_AZ:     az_reg <= rnd30[16:0];
            D_G00:    g00_reg <= rnd8_one[25:0];
            D_G10:    g10_reg <= rnd8_dbl[25:0];
            D_G20:    g20_reg <= rnd8_dbl[25:0];
            D_G02:    g02_reg <= rnd8_dbl[25:0];
            D_G12:    g12_reg <= rnd8_dbl[25:0];
            D_G22:    g22_reg <= rnd8_one[25:0];
            D_R20:    r20_reg <= rnd8_dbl[26:0];
            D_R21:    r21_reg <= rnd8_dbl[26:0];
            D_R22:    r22_reg <= rnd8_one[26:0];
            D_VY_NEG: vy_reg <= -acc_reg[XY_W-1:0];
            D_VX_ACC: vx_reg <= acc_reg[XY_W-1:0];
            default:  ;
        endcase

        if (cmd.out_load)
        begin
            yaw_out_reg   <= yaw_sat[15:0];
            pitch_out_reg <= pitch_sat[14:0];
            rp_out_reg    <= rp_sat[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign chassis_yaw    = yaw_out_reg;
    assign chassis_pitch  = pitch_out_reg;
    assign relative_pitch = rp_out_reg;

endmodule

// File: rtl/qrpy_ctrl.sv
// qrpy_ctrl: microprogram sequencer, one datapath step per cycle but for waits.
// Depends on qrpy_pkg.
module qrpy_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qrpy_pkg::dp_stat_t  stat,
    output qrpy_pkg::dp_cmd_t   cmd
);
    import qrpy_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          u;
    logic            run, go;

    assign u   = ucode(pc_reg);
    assign run = (state_reg == S_RUN);

    always_comb
    begin
        case (u.kind)
            K_WCOR:   go = ~stat.cordic_busy;
            K_WSQRT:  go = ~stat.sqrt_busy;
            K_WWRAP:  go = stat.err_ok;
            K_FINISH: go = ~stat.out_busy;
            default:  go = 1'b1;
        endcase
    end

    always_comb
    begin
        cmd.in_load      = ~run && in_valid;
        cmd.mac          = run ? u.mac : MAC_NONE;
        cmd.opa          = u.opa;
        cmd.opb          = u.opb;
        cmd.dst          = run ? u.dst : D_NONE;
        cmd.cordic_start = run && (u.kind == K_VEC || u.kind == K_ROT);
        cmd.cordic_rot   = (u.kind == K_ROT);
        cmd.sqrt_start   = run && (u.kind == K_SQRT);
        cmd.wrap_en      = run && (u.kind == K_WWRAP);
        cmd.out_load     = run && (u.kind == K_FINISH) && go;
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                pc_next = '0;
                if (in_valid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (go)
                begin
                    if (u.kind == K_FINISH || pc_reg == UC_LAST)
                    begin
                        state_next = S_IDLE;
                        pc_next    = '0;
                    end
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                pc_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    assign in_stall = run;

endmodule

// File: rtl/quaternion_relative_pitch_yaw.sv
// quaternion_relative_pitch_yaw: top level, sequencer plus datapath.
// Depends on qrpy_pkg, qrpy_ctrl and qrpy_dp.
//
// One transfer in gives one transfer out: chassis yaw, chassis pitch and gimbal pitch
// relative to the chassis, in radians scaled by 2^ANGLE_FRAC_BITS. A new chassis
// quaternion is stored when chassis_valid is set as an input is taken; until the first
// one the stored quaternion is all zero. Input transfers are stalled while a result is
// computed, and the run waits at the wrap step until the yaw error lies within
// [-pi, pi]. The next input can be taken in the cycle after the result loads.
// Throughput is set by the single shared CORDIC, the iterative square root and the
// one multiplier.
// The next item is taken as soon as the previous result is in the output register.
module quaternion_relative_pitch_yaw #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               chassis_valid,
    input  logic signed [15:0] chassis_w,
    input  logic signed [15:0] chassis_x,
    input  logic signed [15:0] chassis_y,
    input  logic signed [15:0] chassis_z,
    input  logic signed [15:0] gimbal_w,
    input  logic signed [15:0] gimbal_x,
    input  logic signed [15:0] gimbal_y,
    input  logic signed [15:0] gimbal_z,
    input  logic signed [15:0] relative_yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] chassis_yaw,
    output logic signed [14:0] chassis_pitch,
    output logic signed [15:0] relative_pitch
);
    import qrpy_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    qrpy_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    qrpy_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .chassis_valid  (chassis_valid),
        .chassis_w      (chassis_w),
        .chassis_x      (chassis_x),
        .chassis_y      (chassis_y),
        .chassis_z      (chassis_z),
        .gimbal_w       (gimbal_w),
        .gimbal_x       (gimbal_x),
        .gimbal_y       (gimbal_y),
        .gimbal_z       (gimbal_z),
        .relative_yaw   (relative_yaw),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .chassis_yaw    (chassis_yaw),
        .chassis_pitch  (chassis_pitch),
        .relative_pitch (relative_pitch)
    );

endmodule
